/* design/bcta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcta_pkg
// Shared types, sizes and operation codes of the contiguous tile allocator.
// ----------------------------------------------------------------------------
package bcta_pkg;

   localparam int WORD_BITS = 32;
   localparam int BG_TILES  = 2048;
   localparam int SPR_TILES = 1024;
   localparam int BG_WORDS  = BG_TILES / WORD_BITS;
   localparam int SPR_WORDS = SPR_TILES / WORD_BITS;
   localparam int MAP_COUNT = BG_WORDS / 2;
   localparam int BG_AW     = $clog2(BG_WORDS);
   localparam int SPR_AW    = $clog2(SPR_WORDS);

   localparam logic [2:0] OP_TILE_ALLOC = 3'd0;
   localparam logic [2:0] OP_TILE_FREE  = 3'd1;
   localparam logic [2:0] OP_MAP_ALLOC  = 3'd2;
   localparam logic [2:0] OP_MAP_FREE   = 3'd3;
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic        zone;
      logic [11:0] count;
      logic [10:0] first_index;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [10:0] granted_index;
   } rsp_type;

   // Finished request handed from the sequencer to the response register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   // One RAM port bundle: read address plus write
   typedef struct packed {
      logic [BG_AW-1:0]     raddr;
      logic                 we;
      logic [BG_AW-1:0]     waddr;
      logic [WORD_BITS-1:0] wdata;
   } mem_port_type;

endpackage

/* design/bcta_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcta_ram #(
   parameter int WIDTH = bcta_pkg::WORD_BITS,
   parameter int DEPTH = bcta_pkg::BG_WORDS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/bcta_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcta_ctrl
// Request sequencer: bitmap scans, read-modify-write marking and sweeps.
// ----------------------------------------------------------------------------
module bcta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bcta_pkg::req_type    req_payload,
   output bcta_pkg::mem_port_type bg_port,
   output bcta_pkg::mem_port_type spr_port,
   input  logic [bcta_pkg::WORD_BITS-1:0] bg_rdata,
   input  logic [bcta_pkg::WORD_BITS-1:0] spr_rdata,
   output bcta_pkg::done_type   done,
   input  logic                 done_take
);
   import bcta_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_T_RD  = 4'd2;
   localparam logic [3:0] S_T_EX  = 4'd3;
   localparam logic [3:0] S_T_BIT = 4'd4;
   localparam logic [3:0] S_M_RD  = 4'd5;
   localparam logic [3:0] S_M_WR  = 4'd6;
   localparam logic [3:0] S_P_RD  = 4'd7;
   localparam logic [3:0] S_P_EX  = 4'd8;
   localparam logic [3:0] S_FILL  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam logic [WORD_BITS-1:0] ONES = '1;
   localparam logic [6:0]  BG_LAST  = 7'(BG_WORDS - 1);
   localparam logic [6:0]  SPR_LAST = 7'(SPR_WORDS - 1);
   localparam logic [12:0] BG_T     = 13'(BG_TILES);
   localparam logic [12:0] SPR_T    = 13'(SPR_TILES);
   localparam logic [13:0] MAP_WEND = 14'(BG_WORDS);
   localparam logic [12:0] MAP_MAX  = 13'(MAP_COUNT);

   logic [3:0]           state_ff, state_in;
   logic                 zone_ff, zone_in;
   logic                 setm_ff, setm_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [11:0]          count_ff, count_in;
   logic [6:0]           widx_ff, widx_in;
   logic [12:0]          run_ff, run_in;
   logic [10:0]          start_ff, start_in;
   logic [WORD_BITS-1:0] bits_ff, bits_in;
   logic [4:0]           bidx_ff, bidx_in;
   logic                 zflag_ff, zflag_in;
   logic [12:0]          pos_ff, pos_in;
   logic [12:0]          end_ff, end_in;
   logic                 fval_ff, fval_in;
   logic                 ok_ff, ok_in;
   logic [10:0]          gidx_ff, gidx_in;

   logic [WORD_BITS-1:0] rword;
   logic [12:0]          tiles;
   logic [6:0]           last_word;
   logic [12:0]          fsum, tend;
   logic [13:0]          msum, mend, mstart;
   logic [10:0]          wbase, tstart;
   logic [12:0]          run_next;
   logic [12:0]          end_m1, wlast, lastt;
   logic [4:0]           lo, hi;
   logic [WORD_BITS-1:0] mask, mword;
   logic [12:0]          next_pos;
   logic                 mzero;
   logic                 accept;

   assign rword     = zone_ff ? spr_rdata : bg_rdata;
   assign tiles     = req_payload.zone ? SPR_T : BG_T;
   assign last_word = zone_ff ? SPR_LAST : BG_LAST;
   assign fsum      = {2'b0, req_payload.first_index} + {1'b0, req_payload.count};
   assign tend      = (fsum < tiles) ? fsum : tiles;
   assign msum      = {fsum, 1'b0};
   assign mend      = (msum < MAP_WEND) ? msum : MAP_WEND;
   assign mstart    = {2'b0, req_payload.first_index, 1'b0};
   assign wbase     = {widx_ff[5:0], 5'b0};
   assign end_m1    = end_ff - 13'd1;
   assign wlast     = {pos_ff[12:5], 5'h1f};
   assign lastt     = (end_m1 < wlast) ? end_m1 : wlast;
   assign lo        = pos_ff[4:0];
   assign hi        = lastt[4:0];
   assign mask      = (ONES << lo) & (ONES >> (5'd31 - hi));
   assign mword     = setm_ff ? (rword | mask) : (rword & ~mask);
   assign next_pos  = {pos_ff[12:5] + 8'd1, 5'b0};
   assign accept    = req_valid && !req_stall;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      zone_in    = zone_ff;
      setm_in    = setm_ff;
      clr_rsp_in = clr_rsp_ff;
      count_in   = count_ff;
      widx_in    = widx_ff;
      run_in     = run_ff;
      start_in   = start_ff;
      bits_in    = bits_ff;
      bidx_in    = bidx_ff;
      zflag_in   = zflag_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      fval_in    = fval_ff;
      ok_in      = ok_ff;
      gidx_in    = gidx_ff;
      tstart     = start_ff;
      run_next   = run_ff;
      mzero      = 1'b0;
      bg_port    = '0;
      spr_port   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               zone_in  = req_payload.zone;
               count_in = req_payload.count;
               ok_in    = 1'b0;
               gidx_in  = '0;
               run_in   = '0;
               case (req_payload.op)
                  OP_TILE_ALLOC: begin
                     if (req_payload.count == 12'd0 || {1'b0, req_payload.count} > tiles) begin
                        state_in = S_DONE;
                     end else begin
                        widx_in  = '0;
                        state_in = S_T_RD;
                     end
                  end
                  OP_TILE_FREE: begin
                     ok_in = 1'b1;
                     if ({2'b0, req_payload.first_index} >= tend) begin
                        state_in = S_DONE;
                     end else begin
                        pos_in   = {2'b0, req_payload.first_index};
                        end_in   = tend;
                        setm_in  = 1'b0;
                        state_in = S_M_RD;
                     end
                  end
                  OP_MAP_ALLOC: begin
                     if (req_payload.count == 12'd0 || {1'b0, req_payload.count} > MAP_MAX) begin
                        state_in = S_DONE;
                     end else begin
                        widx_in  = BG_LAST;
                        state_in = S_P_RD;
                     end
                  end
                  OP_MAP_FREE: begin
                     ok_in = 1'b1;
                     if (mstart >= mend) begin
                        state_in = S_DONE;
                     end else begin
                        widx_in  = mstart[6:0];
                        end_in   = mend[12:0];
                        fval_in  = 1'b0;
                        state_in = S_FILL;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     widx_in    = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLR: begin
            bg_port.we     = 1'b1;
            bg_port.waddr  = widx_ff[5:0];
            spr_port.we    = (widx_ff < 7'(SPR_WORDS));
            spr_port.waddr = widx_ff[5:0];
            widx_in        = widx_ff + 7'd1;
            if (widx_ff == BG_LAST) begin
               ok_in      = 1'b1;
               gidx_in    = '0;
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_T_RD: begin
            bg_port.raddr  = widx_ff[5:0];
            spr_port.raddr = widx_ff[5:0];
            state_in       = S_T_EX;
         end
         S_T_EX: begin
            if (rword != ONES && rword != '0) begin
               bits_in  = rword;
               bidx_in  = '0;
               state_in = S_T_BIT;
            end else begin
               if (rword == '0) begin
                  tstart   = (run_ff == 13'd0) ? wbase : start_ff;
                  run_next = run_ff + 13'(WORD_BITS);
               end else begin
                  run_next = '0;
               end
               run_in   = run_next;
               start_in = tstart;
               if (rword == '0 && run_next >= {1'b0, count_ff}) begin
                  gidx_in  = tstart;
                  pos_in   = {2'b0, tstart};
                  end_in   = {2'b0, tstart} + {1'b0, count_ff};
                  setm_in  = 1'b1;
                  state_in = S_M_RD;
               end else if (widx_ff == last_word) begin
                  state_in = S_DONE;
               end else begin
                  widx_in  = widx_ff + 7'd1;
                  state_in = S_T_RD;
               end
            end
         end
         S_T_BIT: begin
            if (bits_ff[bidx_ff]) begin
               run_next = '0;
            end else begin
               tstart   = (run_ff == 13'd0) ? (wbase | {6'b0, bidx_ff}) : start_ff;
               run_next = run_ff + 13'd1;
            end
            run_in   = run_next;
            start_in = tstart;
            bidx_in  = bidx_ff + 5'd1;
            if (!bits_ff[bidx_ff] && run_next == {1'b0, count_ff}) begin
               gidx_in  = tstart;
               pos_in   = {2'b0, tstart};
               end_in   = {2'b0, tstart} + {1'b0, count_ff};
               setm_in  = 1'b1;
               state_in = S_M_RD;
            end else if (bidx_ff == 5'd31) begin
               if (widx_ff == last_word) begin
                  state_in = S_DONE;
               end else begin
                  widx_in  = widx_ff + 7'd1;
                  state_in = S_T_RD;
               end
            end
         end
         S_M_RD: begin
            bg_port.raddr  = pos_ff[10:5];
            spr_port.raddr = pos_ff[10:5];
            state_in       = S_M_WR;
         end
         S_M_WR: begin
            bg_port.we     = !zone_ff;
            bg_port.waddr  = pos_ff[10:5];
            bg_port.wdata  = mword;
            spr_port.we    = zone_ff;
            spr_port.waddr = pos_ff[10:5];
            spr_port.wdata = mword;
            pos_in         = next_pos;
            if (next_pos >= end_ff) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_M_RD;
            end
         end
         S_P_RD: begin
            bg_port.raddr = widx_ff[5:0];
            state_in      = S_P_EX;
         end
         S_P_EX: begin
            if (widx_ff[0]) begin
               zflag_in = (bg_rdata == '0);
               widx_in  = widx_ff - 7'd1;
               state_in = S_P_RD;
            end else begin
               mzero    = zflag_ff && (bg_rdata == '0);
               run_next = mzero ? (run_ff + 13'd1) : 13'd0;
               run_in   = run_next;
               if (mzero && run_next >= {1'b0, count_ff}) begin
                  gidx_in  = {5'b0, widx_ff[6:1]};
                  end_in   = {6'b0, widx_ff} + {count_ff, 1'b0};
                  fval_in  = 1'b1;
                  state_in = S_FILL;
               end else if (widx_ff == 7'd0) begin
                  state_in = S_DONE;
               end else begin
                  widx_in  = widx_ff - 7'd1;
                  state_in = S_P_RD;
               end
            end
         end
         S_FILL: begin
            bg_port.we    = 1'b1;
            bg_port.waddr = widx_ff[5:0];
            bg_port.wdata = fval_ff ? ONES : '0;
            widx_in       = widx_ff + 7'd1;
            if ({6'b0, widx_ff} + 13'd1 >= end_ff) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         widx_ff    <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         widx_ff    <= widx_in;
         clr_rsp_ff <= clr_rsp_in;
      end
      zone_ff  <= zone_in;
      setm_ff  <= setm_in;
      count_ff <= count_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      bits_ff  <= bits_in;
      bidx_ff  <= bidx_in;
      zflag_ff <= zflag_in;
      pos_ff   <= pos_in;
      end_ff   <= end_in;
      fval_ff  <= fval_in;
      ok_ff    <= ok_in;
      gidx_ff  <= gidx_in;
   end

   assign done.valid             = (state_ff == S_DONE);
   assign done.rsp.ok            = ok_ff;
   assign done.rsp.granted_index = ok_ff ? gidx_ff : '0;

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done.valid && !done_take |=> done.valid && $stable(done.rsp))
      else $error("finished request changed before it was taken");

   a_clear_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.op == OP_CLEAR_ALL |=> state_ff == S_CLR)
      else $error("clear-all did not start the sweep");

   a_bit_mixed: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_T_BIT |-> bits_ff != ONES && bits_ff != '0)
      else $error("bit walk entered on a full or empty word");

   a_fill_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> bg_port.we && !spr_port.we)
      else $error("map fill without a background write");

endmodule

/* design/bitmap_contiguous_tile_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_tile_allocator
// First-fit tile and map allocator over background and sprite bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (op, zone, count, first_index); it is taken when
//   req_valid is high and req_stall is low. Every request gives exactly one
//   response on rsp_* (ok, granted_index), taken when rsp_valid is high and
//   rsp_stall is low.
// Operation:
//   One request at a time. The bitmaps sit in two RAMs with registered read
//   data (64 and 32 words of 32 bits); the work is set by the word scan:
//   - tile alloc: reads each word; a full or empty word is judged whole, a
//     mixed word is walked bit by bit, then each word of the run is marked;
//   - tile free: read-modify-write of each touched word;
//   - map alloc: reads the words in pairs, scanning downward from the top,
//     then fills the words of the granted maps;  map free: clears each word;
//   - clear all: a sweep that writes every word of both RAMs to zero.
//   The response is then handed to the output register.
// Reset:
//   After reset the block sweeps both RAMs to zero, holding req_stall high,
//   then all tiles are free.
// Stall:
//   The response waits in the output register while rsp_stall is high;
//   the next request is still taken and worked, and its result waits in
//   the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_contiguous_tile_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bcta_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bcta_pkg::rsp_type rsp_payload
);
   import bcta_pkg::*;

   mem_port_type         bg_port, spr_port;
   logic [WORD_BITS-1:0] bg_rdata, spr_rdata;
   done_type             done;
   logic                 done_take;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff;

   // Background bitmap: one bit per tile, maps are aligned word pairs
   bcta_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BG_WORDS)
   ) u_bg_ram (
      .clock (clock),
      .we    (bg_port.we),
      .waddr (bg_port.waddr),
      .wdata (bg_port.wdata),
      .raddr (bg_port.raddr),
      .rdata (bg_rdata)
   );

   // Sprite bitmap: lower address bits of its own port bundle
   bcta_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (SPR_WORDS)
   ) u_spr_ram (
      .clock (clock),
      .we    (spr_port.we),
      .waddr (spr_port.waddr[SPR_AW-1:0]),
      .wdata (spr_port.wdata),
      .raddr (spr_port.raddr[SPR_AW-1:0]),
      .rdata (spr_rdata)
   );

   bcta_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .bg_port     (bg_port),
      .spr_port    (spr_port),
      .bg_rdata    (bg_rdata),
      .spr_rdata   (spr_rdata),
      .done        (done),
      .done_take   (done_take)
   );

   // Load the output register when it is empty or being drained
   assign done_take    = done.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = done_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_take) begin
         rsp_payload_ff <= done.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contiguous tile allocator.
// ----------------------------------------------------------------------------
// A bit-accurate model of both bitmaps predicts the response of every request
// when the request list is built. A bursty driver feeds the list to the block.
// A monitor stalls on its own pattern and checks each response, in order,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import bcta_pkg::*;

   localparam int TIMEOUT_CYCLES = 12_000_000;
   localparam int RANDOM_REQS    = 1450;
   localparam int DRAIN_EVERY    = 300;

   // A queued request; drain_first holds it until every response is back
   typedef struct {
      req_type req;
      bit      drain_first;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_payload;

   bitmap_contiguous_tile_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Allocation state as the block should hold it
   // ---------------------------------------------------------------------
   logic [WORD_BITS-1:0] bg_words  [BG_WORDS];
   logic [WORD_BITS-1:0] spr_words [SPR_WORDS];

   pending_type pending_reqs[$];
   rsp_type     expected_rsps[$];

   // Granted regions, kept so that most frees release something real
   int tile_zone[$];
   int tile_first[$];
   int tile_len[$];
   int map_start[$];
   int map_len[$];

   int mismatches = 0;
   int rsps_seen  = 0;
   int reqs_sent  = 0;
   int cycles     = 0;

   function automatic logic tile_bit(bit sprite, int t);
      if (sprite)
         return spr_words[t / WORD_BITS][t % WORD_BITS];
      return bg_words[t / WORD_BITS][t % WORD_BITS];
   endfunction

   function automatic void mark_tile(bit sprite, int t, logic used);
      if (sprite)
         spr_words[t / WORD_BITS][t % WORD_BITS] = used;
      else
         bg_words[t / WORD_BITS][t % WORD_BITS] = used;
   endfunction

   function automatic void clear_bitmaps();
      foreach (bg_words[i]) bg_words[i] = '0;
      foreach (spr_words[i]) spr_words[i] = '0;
   endfunction

   // Apply one request to the model and return the response it gives
   function automatic rsp_type predict_alloc(req_type r);
      rsp_type res;
      bit      sprite;
      int      tiles, cnt, w, run, run_start, m;
      bit      good;
      logic [WORD_BITS-1:0] word;
      res    = '0;
      sprite = r.zone;
      tiles  = sprite ? SPR_TILES : BG_TILES;
      cnt    = int'(r.count);
      case (r.op)
         OP_TILE_ALLOC: begin
            if (cnt != 0 && cnt <= tiles) begin
               // skip the words that are completely full
               w = 0;
               while (w < tiles / WORD_BITS) begin
                  word = sprite ? spr_words[w] : bg_words[w];
                  if (word != '1) break;
                  w++;
               end
               run = 0;
               run_start = 0;
               for (int t = w * WORD_BITS; t < tiles; t++) begin
                  if (tile_bit(sprite, t)) begin
                     run = 0;
                  end else begin
                     if (run == 0) run_start = t;
                     run++;
                     if (run == cnt) begin
                        for (int k = 0; k < cnt; k++) mark_tile(sprite, run_start + k, 1'b1);
                        res.ok = 1'b1;
                        res.granted_index = run_start[10:0];
                        break;
                     end
                  end
               end
            end
         end
         OP_TILE_FREE: begin
            for (int k = 0; k < cnt; k++) begin
               if (int'(r.first_index) + k >= tiles) break;
               mark_tile(sprite, int'(r.first_index) + k, 1'b0);
            end
            res.ok = 1'b1;
         end
         OP_MAP_ALLOC: begin
            // search downward, one map (two words) at a time
            if (cnt != 0 && cnt <= MAP_COUNT) begin
               m = MAP_COUNT - cnt + 1;
               while (m > 0) begin
                  m--;
                  good = 1'b1;
                  for (int j = 0; j < 2 * cnt; j++) begin
                     if (bg_words[2 * m + j] != '0) begin
                        good = 1'b0;
                        break;
                     end
                  end
                  if (good) begin
                     for (int j = 0; j < 2 * cnt; j++) bg_words[2 * m + j] = '1;
                     res.ok = 1'b1;
                     res.granted_index = m[10:0];
                     break;
                  end
               end
            end
         end
         OP_MAP_FREE: begin
            for (int k = 0; k < cnt; k++) begin
               if (int'(r.first_index) + k >= MAP_COUNT) break;
               bg_words[2 * (int'(r.first_index) + k)]     = '0;
               bg_words[2 * (int'(r.first_index) + k) + 1] = '0;
            end
            res.ok = 1'b1;
         end
         OP_CLEAR_ALL: begin
            clear_bitmaps();
            res.ok = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Queue a request, predict its response and remember what it granted
   task automatic queue_req(logic [2:0] op, logic zone, int cnt, int first, bit drain);
      pending_type p;
      rsp_type     r;
      p.req.op          = op;
      p.req.zone        = zone;
      p.req.count       = cnt[11:0];
      p.req.first_index = first[10:0];
      p.drain_first     = drain;
      r = predict_alloc(p.req);
      pending_reqs.push_back(p);
      expected_rsps.push_back(r);
      if (r.ok && op == OP_TILE_ALLOC) begin
         tile_zone.push_back(int'(zone));
         tile_first.push_back(int'(r.granted_index));
         tile_len.push_back(int'(p.req.count));
      end else if (r.ok && op == OP_MAP_ALLOC) begin
         map_start.push_back(int'(r.granted_index));
         map_len.push_back(int'(p.req.count));
      end else if (op == OP_CLEAR_ALL) begin
         tile_zone.delete();
         tile_first.delete();
         tile_len.delete();
         map_start.delete();
         map_len.delete();
      end
   endtask

   task automatic build_requests();
      int sel, idx, cnt;
      bit drain;
      clear_bitmaps();
      // directed corners
      queue_req(OP_TILE_ALLOC, 1'b0, 0, 0, 1'b0);       // zero count alloc
      queue_req(OP_TILE_ALLOC, 1'b0, 1, 0, 1'b0);
      queue_req(OP_TILE_ALLOC, 1'b1, 1, 0, 1'b0);
      queue_req(OP_TILE_ALLOC, 1'b0, 2048, 0, 1'b0);    // no room left for the pool
      queue_req(OP_TILE_ALLOC, 1'b1, 4095, 0, 1'b0);    // larger than the pool
      queue_req(OP_TILE_FREE, 1'b0, 0, 0, 1'b0);        // zero count free
      queue_req(OP_TILE_FREE, 1'b1, 100, 1000, 1'b0);   // free past the pool
      queue_req(OP_TILE_FREE, 1'b0, 4095, 2047, 1'b0);
      queue_req(OP_TILE_ALLOC, 1'b1, 1024, 0, 1'b0);    // whole sprite pool
      queue_req(OP_TILE_ALLOC, 1'b1, 1, 0, 1'b0);       // pool not full: whole-pool request failed
      queue_req(OP_TILE_FREE, 1'b1, 5, 0, 1'b0);        // free granted and never-granted tiles
      queue_req(OP_MAP_ALLOC, 1'b1, 1, 0, 1'b0);        // zone ignored
      queue_req(OP_MAP_ALLOC, 1'b0, 0, 0, 1'b0);
      queue_req(OP_MAP_ALLOC, 1'b0, 33, 0, 1'b0);
      queue_req(OP_MAP_FREE, 1'b0, 4095, 2047, 1'b0);
      queue_req(OP_MAP_FREE, 1'b0, 40, 0, 1'b0);        // free every map, past the last one
      queue_req(OP_MAP_ALLOC, 1'b0, 32, 0, 1'b0);       // every map
      queue_req(OP_TILE_ALLOC, 1'b0, 1, 0, 1'b0);       // all words full
      queue_req(3'd5, 1'b0, 7, 3, 1'b0);
      queue_req(3'd6, 1'b1, 4095, 2047, 1'b0);
      queue_req(3'd7, 1'b0, 1, 1, 1'b0);
      queue_req(OP_CLEAR_ALL, 1'b1, 0, 0, 1'b1);
      queue_req(OP_TILE_ALLOC, 1'b0, 2048, 0, 1'b0);
      queue_req(OP_TILE_FREE, 1'b0, 2048, 0, 1'b0);
      // random traffic, mostly alloc/free pairs
      for (int i = 0; i < RANDOM_REQS; i++) begin
         drain = (i % DRAIN_EVERY == DRAIN_EVERY - 1);
         sel = $urandom_range(99);
         if (sel < 40) begin
            idx = $urandom_range(99);
            cnt = idx < 80 ? $urandom_range(40, 1) :
                  idx < 95 ? $urandom_range(300, 1) : $urandom_range(4095);
            queue_req(OP_TILE_ALLOC, 1'($urandom_range(1)), cnt, $urandom_range(2047),
                      drain);
         end else if (sel < 70) begin
            if (tile_first.size() != 0 && $urandom_range(9) != 0) begin
               idx = $urandom_range(tile_first.size() - 1);
               queue_req(OP_TILE_FREE, 1'(tile_zone[idx]), tile_len[idx], tile_first[idx],
                         drain);
               tile_zone.delete(idx);
               tile_first.delete(idx);
               tile_len.delete(idx);
            end else begin
               queue_req(OP_TILE_FREE, 1'($urandom_range(1)), $urandom_range(4095),
                         $urandom_range(2047), drain);
            end
         end else if (sel < 82) begin
            cnt = $urandom_range(9) != 0 ? $urandom_range(4, 1) : $urandom_range(4095);
            queue_req(OP_MAP_ALLOC, 1'($urandom_range(1)), cnt, $urandom_range(2047), drain);
         end else if (sel < 90) begin
            if (map_start.size() != 0 && $urandom_range(4) != 0) begin
               idx = $urandom_range(map_start.size() - 1);
               queue_req(OP_MAP_FREE, 1'($urandom_range(1)), map_len[idx], map_start[idx],
                         drain);
               map_start.delete(idx);
               map_len.delete(idx);
            end else begin
               queue_req(OP_MAP_FREE, 1'($urandom_range(1)), $urandom_range(4095),
                         $urandom_range(2047), drain);
            end
         end else if (sel < 92) begin
            queue_req(OP_CLEAR_ALL, 1'($urandom_range(1)), $urandom_range(4095),
                      $urandom_range(2047), drain);
         end else begin
            // noise: any op, any field value
            queue_req(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom_range(4095),
                      $urandom_range(2047), drain);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of requests separated by random gaps
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else if (req_valid && req_stall) begin
         // hold the stalled request
      end else begin
         if (req_valid) reqs_sent++;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      (!pending_reqs[0].drain_first || rsps_seen == reqs_sent)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_reqs[0].req;
            void'(pending_reqs.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(30, 1);
               gap_left   = $urandom_range(3) == 0 ? 0 : $urandom_range(20);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: own stall pattern, in-order compare against predictions
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int flow_left  = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsps_seen <= rsps_seen + 1;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response ok=%0b index=%0d",
                           rsp_payload.ok, rsp_payload.granted_index);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.ok !== want.ok ||
                   rsp_payload.granted_index !== want.granted_index) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d: expected ok=%0b index=%0d, got ok=%0b index=%0d",
                              rsps_seen, want.ok, want.granted_index,
                              rsp_payload.ok, rsp_payload.granted_index);
               end
            end
         end
         // alternate stall and flow stretches; some flow stretches are long
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (flow_left > 0) begin
            flow_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = $urandom_range(2) == 0 ? 0 : $urandom_range(15);
            flow_left  = $urandom_range(4) == 0 ? $urandom_range(200) : $urandom_range(8);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      build_requests();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // wait for every request to go out and every response to come back
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
